>>> rtl/clp_pkg.sv
// Shared types, constants and helper functions for the loop-count header parser.
package clp_pkg;

    localparam int MAX_ID_BYTES = 16;
    localparam int COUNT_BITS   = 16;
    localparam int ID_LEN_W     = 5;
    localparam int LIT_LEN      = 7;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // configuration register indexes
    localparam logic [2:0] CFG_ENABLE        = 3'd0;
    localparam logic [2:0] CFG_MAX_LOOPS     = 3'd1;
    localparam logic [2:0] CFG_REJECT_STATUS = 3'd2;
    localparam logic [2:0] CFG_ID_LENGTH     = 3'd3;
    localparam logic [2:0] CFG_ID_BYTES_LOW  = 3'd4;
    localparam logic [2:0] CFG_ID_BYTES_HIGH = 3'd5;

    // reset values of the configuration registers
    localparam logic        RST_ENABLE        = 1'b0;
    localparam logic [15:0] RST_MAX_LOOPS     = 16'd10;
    localparam logic [9:0]  RST_REJECT_STATUS = 10'd508;
    localparam logic [4:0]  RST_ID_LENGTH     = 5'd5;
    localparam logic [63:0] RST_ID_BYTES_LOW  = 64'd517248477038;
    localparam logic [63:0] RST_ID_BYTES_HIGH = 64'd0;

    // entry parse phases
    localparam logic [2:0] PH_LEAD = 3'd0;
    localparam logic [2:0] PH_ID   = 3'd1;
    localparam logic [2:0] PH_LIT  = 3'd2;
    localparam logic [2:0] PH_NUM  = 3'd3;
    localparam logic [2:0] PH_SKIP = 3'd4;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5a;

    typedef struct packed {
        logic [7:0] header_byte;
        logic       last_byte;
        logic       no_header;
    } t_in;

    typedef struct packed {
        logic [15:0] loop_count;
        logic [15:0] forward_count;
        logic        over_limit;
        logic [9:0]  response_status;
    } t_out;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
            r = c | 8'h20;
        end
        return r;
    endfunction

    // " loops=" one character at a time
    function automatic logic [7:0] lit_char(input logic [2:0] i);
        logic [7:0] r;
        case (i)
            3'd0:    r = 8'h20;
            3'd1:    r = 8'h6c;
            3'd2:    r = 8'h6f;
            3'd3:    r = 8'h6f;
            3'd4:    r = 8'h70;
            3'd5:    r = 8'h73;
            3'd6:    r = 8'h3d;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/cdn_loop_count_parser_core.sv
// Loop-count header parser: byte-serial parse of a loop-detection header value.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one header byte per
// transaction, with last_byte marking the final byte. A transaction with
// no_header set ends the header at once and reports a count of 0.
// Output channel (o_out_valid / i_out_ready / o_out_data) carries one result per
// header: loop count, count plus one (saturating), over-limit flag and response status.
// Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data) is
// always ready and writes one register per transaction; write it only while idle.
//
// Throughput: one byte per cycle while the output is not stalled. Each byte updates
// the parse state in the cycle it is accepted; the result for a final byte sits in
// the output register from the next cycle.
// The output register decouples the two sides: input is taken while the output
// is empty or being drained in the same cycle. A stalled receiver holds the
// result and stops all intake until that result is taken.
// Reset (synchronous, active low) clears the parse state, empties the output
// register and loads the default configuration.
module cdn_loop_count_parser_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  clp_pkg::t_in    i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output clp_pkg::t_out   o_out_data,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [2:0]      i_cfg_index,
    input  logic [63:0]     i_cfg_data
);

    localparam int CB = clp_pkg::COUNT_BITS;

    // configuration
    logic        r_enable;
    logic [15:0] r_max_loops;
    logic [9:0]  r_reject_status;
    logic [4:0]  r_id_length;
    logic [63:0] r_id_low;
    logic [63:0] r_id_high;

    // parse state
    logic [2:0]    r_phase,       n_phase;
    logic [4:0]    r_id_pos,      n_id_pos;
    logic [2:0]    r_lit_pos,     n_lit_pos;
    logic [CB-1:0] r_digit,       n_digit;
    logic          r_seen,        n_seen;
    logic          r_space,       n_space;
    logic          r_match,       n_match;
    logic [CB-1:0] r_count,       n_count;

    logic          r_out_valid;
    clp_pkg::t_out r_out,         n_out;

    logic          in_fire;
    logic          emit;
    logic [7:0]    b;
    logic [7:0]    b_low;
    logic          len_ok;
    logic [15:0][7:0] id_arr;
    logic [2:0]    ph_e;
    logic [4:0]    pos_e;
    logic [CB+3:0] mac;
    logic [CB-1:0] fin_count;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign b      = i_in_data.header_byte;
    assign b_low  = clp_pkg::to_lower(b);
    assign len_ok = (r_id_length != 5'd0) &&
                    (r_id_length <= 5'(clp_pkg::MAX_ID_BYTES));
    assign id_arr = {r_id_high, r_id_low};
    assign ph_e   = (r_phase == clp_pkg::PH_LEAD) ? clp_pkg::PH_ID : r_phase;
    assign pos_e  = (r_phase == clp_pkg::PH_LEAD) ? 5'd0 : r_id_pos;
    // value * 10 + digit
    assign mac    = {1'b0, r_digit, 3'b000} + {3'b000, r_digit, 1'b0} +
                    (CB+4)'(b[3:0]);
    assign emit   = i_in_data.no_header || i_in_data.last_byte;

    always_comb begin
        n_phase   = r_phase;
        n_id_pos  = r_id_pos;
        n_lit_pos = r_lit_pos;
        n_digit   = r_digit;
        n_seen    = r_seen;
        n_space   = r_space;
        n_match   = r_match;
        n_count   = r_count;

        // byte step (commas skip this and go straight to end of entry)
        if (b != clp_pkg::CH_COMMA && !(r_phase == clp_pkg::PH_LEAD && b == clp_pkg::CH_SPACE))
        begin
            case (ph_e)
                clp_pkg::PH_ID: begin
                    if (b == clp_pkg::CH_SEMI) begin
                        if (len_ok && pos_e == r_id_length) begin
                            n_phase   = clp_pkg::PH_LIT;
                            n_lit_pos = 3'd0;
                        end else begin
                            n_phase = clp_pkg::PH_SKIP;
                        end
                    end else if (len_ok && pos_e < r_id_length &&
                                 b_low == clp_pkg::to_lower(id_arr[pos_e[3:0]])) begin
                        n_phase  = clp_pkg::PH_ID;
                        n_id_pos = pos_e + 5'd1;
                    end else begin
                        n_phase = clp_pkg::PH_SKIP;
                    end
                end
                clp_pkg::PH_LIT: begin
                    if (r_lit_pos < 3'(clp_pkg::LIT_LEN) &&
                        b_low == clp_pkg::lit_char(r_lit_pos)) begin
                        n_lit_pos = r_lit_pos + 3'd1;
                        if (r_lit_pos == 3'(clp_pkg::LIT_LEN - 1)) begin
                            n_phase = clp_pkg::PH_NUM;
                            n_digit = '0;
                            n_seen  = 1'b0;
                            n_space = 1'b0;
                        end
                    end else begin
                        n_phase = clp_pkg::PH_SKIP;
                    end
                end
                clp_pkg::PH_NUM: begin
                    if (b >= clp_pkg::CH_ZERO && b <= clp_pkg::CH_NINE && !r_space) begin
                        n_digit = (mac > (CB+4)'(clp_pkg::COUNT_MAX)) ?
                                  clp_pkg::COUNT_MAX : mac[CB-1:0];
                        n_seen  = 1'b1;
                    end else if (b == clp_pkg::CH_SPACE && r_seen) begin
                        n_space = 1'b1;
                    end else begin
                        n_phase = clp_pkg::PH_SKIP;
                    end
                end
                default: begin
                end
            endcase
        end

        // end of entry: first complete match wins
        if (b == clp_pkg::CH_COMMA || i_in_data.last_byte) begin
            if (n_phase == clp_pkg::PH_NUM && n_seen && !n_match) begin
                n_match = 1'b1;
                n_count = n_digit;
            end
            n_phase   = clp_pkg::PH_LEAD;
            n_id_pos  = 5'd0;
            n_lit_pos = 3'd0;
            n_digit   = '0;
            n_seen    = 1'b0;
            n_space   = 1'b0;
        end

        if (i_in_data.no_header) begin
            n_match = 1'b0;
            n_count = '0;
        end

        fin_count = n_match ? n_count : '0;
        n_out.loop_count      = fin_count;
        n_out.forward_count   = (fin_count == clp_pkg::COUNT_MAX) ?
                                clp_pkg::COUNT_MAX : fin_count + 16'd1;
        n_out.over_limit      = r_enable && (fin_count > r_max_loops);
        n_out.response_status = n_out.over_limit ? r_reject_status : 10'd0;

        // whole header done: clear for the next one
        if (emit) begin
            n_phase   = clp_pkg::PH_LEAD;
            n_id_pos  = 5'd0;
            n_lit_pos = 3'd0;
            n_digit   = '0;
            n_seen    = 1'b0;
            n_space   = 1'b0;
            n_match   = 1'b0;
            n_count   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable        <= clp_pkg::RST_ENABLE;
            r_max_loops     <= clp_pkg::RST_MAX_LOOPS;
            r_reject_status <= clp_pkg::RST_REJECT_STATUS;
            r_id_length     <= clp_pkg::RST_ID_LENGTH;
            r_id_low        <= clp_pkg::RST_ID_BYTES_LOW;
            r_id_high       <= clp_pkg::RST_ID_BYTES_HIGH;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                clp_pkg::CFG_ENABLE:        r_enable        <= i_cfg_data[0];
                clp_pkg::CFG_MAX_LOOPS:     r_max_loops     <= i_cfg_data[15:0];
                clp_pkg::CFG_REJECT_STATUS: r_reject_status <= i_cfg_data[9:0];
                clp_pkg::CFG_ID_LENGTH:     r_id_length     <= i_cfg_data[4:0];
                clp_pkg::CFG_ID_BYTES_LOW:  r_id_low        <= i_cfg_data;
                clp_pkg::CFG_ID_BYTES_HIGH: r_id_high       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= clp_pkg::PH_LEAD;
            r_id_pos    <= 5'd0;
            r_lit_pos   <= 3'd0;
            r_digit     <= '0;
            r_seen      <= 1'b0;
            r_space     <= 1'b0;
            r_match     <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_phase   <= n_phase;
                r_id_pos  <= n_id_pos;
                r_lit_pos <= n_lit_pos;
                r_digit   <= n_digit;
                r_seen    <= n_seen;
                r_space   <= n_space;
                r_match   <= n_match;
                r_count   <= n_count;
            end
            if (in_fire && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && emit) begin
            r_out <= n_out;
        end
    end

    // no intake while a result is held against a stalled receiver
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted over a held result");

    // a finished header leaves a clean parse state
    a_clear_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && emit) |=> (r_phase == clp_pkg::PH_LEAD && !r_match &&
                               r_count == '0 && r_digit == '0))
        else $error("parse state not cleared after header end");

    // a pass result carries no status
    a_pass_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.over_limit) |-> (r_out.response_status == 10'd0))
        else $error("status set on a passing result");

    a_id_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_id_pos <= 5'(clp_pkg::MAX_ID_BYTES))
        else $error("identifier position beyond maximum");

endmodule
